/* sv/mfv_pkg.sv */
// mfv_pkg: shared types and constants for the message frame validator.
// Used by mfv_cfg, mfv_core and message_frame_validator_top; no dependencies.
`default_nettype none
package mfv_pkg;

	localparam int HEADER_BYTES = 16;
	localparam int CNT_W        = 33;
	localparam int CFG_ADDR_W   = 3;
	localparam int CFG_DATA_W   = 32;
	localparam int OUT_TDATA_W  = 96;

	localparam logic [31:0] MAGIC_RESET   = 32'h1234_5678;
	localparam logic [7:0]  VERSION_RESET = 8'd1;

	typedef enum logic [0:0] {
		REG_MAGIC   = 1'b0,
		REG_VERSION = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_SHORT    = 3'd1,
		ERR_MAGIC    = 3'd2,
		ERR_VERSION  = 3'd3,
		ERR_LENGTH   = 3'd4,
		ERR_CHECKSUM = 3'd5
	} err_t;

	typedef struct packed {
		logic [31:0] magic;
		logic [7:0]  version;
	} cfg_t;

	typedef struct packed {
		logic [31:0] computed_checksum;
		logic [31:0] payload_length;
		logic [15:0] header_flags;
		logic [7:0]  msg_kind;
		err_t        err_code;
		logic        message_ok;
	} result_t;

endpackage
`default_nettype wire

/* sv/mfv_cfg.sv */
// mfv_cfg: APB register file holding the expected magic word and version.
// Depends on mfv_pkg.
`default_nettype none
module mfv_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [mfv_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [mfv_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic      [mfv_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                                 pready,
	output mfv_pkg::cfg_t                        cfg
);
	import mfv_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic   <= MAGIC_RESET;
			cfg_q.version <= VERSION_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_MAGIC:   cfg_q.magic   <= pwdata;
				REG_VERSION: cfg_q.version <= pwdata[7:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MAGIC:   prdata = cfg_q.magic;
			REG_VERSION: prdata = {24'd0, cfg_q.version};
			default:     prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* sv/mfv_core.sv */
// mfv_core: input register, header capture, running checksum, verdict and
// result register. Depends on mfv_pkg.
`default_nettype none
module mfv_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mfv_pkg::cfg_t   cfg,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic [7:0]      in_byte,
	input  wire logic            in_last,
	output logic                 res_valid,
	input  wire logic            res_ready,
	output mfv_pkg::result_t     res
);
	import mfv_pkg::*;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [31:0]      magic_q, magic_n;
	logic [7:0]       ver_q, ver_n;
	logic [7:0]       type_q, type_n;
	logic [15:0]      flags_q, flags_n;
	logic [31:0]      len_q, len_n;
	logic [31:0]      rcsum_q, rcsum_n;
	logic [31:0]      csum_q, csum_n;

	logic             in_hdr;
	logic             is_short;
	logic [CNT_W-1:0] total_exp;
	logic             adv;
	err_t             code;
	result_t          res_n;
	result_t          res_q;
	logic             res_valid_q;

	assign adv      = valid_s1 & (~last_s1 | ~res_valid_q | res_ready);
	assign in_ready = ~valid_s1 | adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	assign in_hdr = (cnt_q[CNT_W-1:4] == '0);

	always_comb begin
		magic_n = magic_q;
		ver_n   = ver_q;
		type_n  = type_q;
		flags_n = flags_q;
		len_n   = len_q;
		rcsum_n = rcsum_q;
		csum_n  = csum_q;
		if (in_hdr) begin
			case (cnt_q[3:0]) inside
				[4'd0:4'd3]:   magic_n = {magic_q[23:0], byte_s1};
				4'd4:          ver_n   = byte_s1;
				4'd5:          type_n  = byte_s1;
				[4'd6:4'd7]:   flags_n = {flags_q[7:0], byte_s1};
				[4'd8:4'd11]:  len_n   = {len_q[23:0], byte_s1};
				default:       rcsum_n = {rcsum_q[23:0], byte_s1};
			endcase
		end else begin
			csum_n = {csum_q[30:0], 1'b0} ^ {24'd0, byte_s1};
		end
		cnt_n = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
	end

	assign is_short  = (cnt_n[CNT_W-1:4] == '0);
	assign total_exp = CNT_W'(HEADER_BYTES) + {1'b0, len_n};

	always_comb begin
		if (is_short) begin
			code = ERR_SHORT;
		end else if (magic_n != cfg.magic) begin
			code = ERR_MAGIC;
		end else if (ver_n != cfg.version) begin
			code = ERR_VERSION;
		end else if (cnt_n != total_exp) begin
			code = ERR_LENGTH;
		end else if (csum_n != rcsum_n) begin
			code = ERR_CHECKSUM;
		end else begin
			code = ERR_NONE;
		end
		res_n.message_ok        = (code == ERR_NONE);
		res_n.err_code          = code;
		res_n.msg_kind          = is_short ? 8'd0  : type_n;
		res_n.header_flags      = is_short ? 16'd0 : flags_n;
		res_n.payload_length    = is_short ? 32'd0 : len_n;
		res_n.computed_checksum = csum_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			magic_q <= '0;
			ver_q   <= '0;
			type_q  <= '0;
			flags_q <= '0;
			len_q   <= '0;
			rcsum_q <= '0;
			csum_q  <= '0;
		end else if (adv) begin
			if (last_s1) begin
				cnt_q   <= '0;
				magic_q <= '0;
				ver_q   <= '0;
				type_q  <= '0;
				flags_q <= '0;
				len_q   <= '0;
				rcsum_q <= '0;
				csum_q  <= '0;
			end else begin
				cnt_q   <= cnt_n;
				magic_q <= magic_n;
				ver_q   <= ver_n;
				type_q  <= type_n;
				flags_q <= flags_n;
				len_q   <= len_n;
				rcsum_q <= rcsum_n;
				csum_q  <= csum_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			res_q <= res_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_clear_after_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> cnt_q == '0 && csum_q == '0)
		else $error("message state not cleared after verdict");

	a_ok_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_q.message_ok == (res_q.err_code == ERR_NONE))
		else $error("message_ok disagrees with err_code");

	a_short_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.err_code == ERR_SHORT |->
		res_q.msg_kind == '0 && res_q.header_flags == '0 &&
		res_q.payload_length == '0 && res_q.computed_checksum == '0)
		else $error("short message result carries header fields");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && last_s1 && res_valid_q && !res_ready)
		else $error("input stalled without a blocked verdict");

endmodule
`default_nettype wire

/* sv/message_frame_validator_top.sv */
// Byte-stream message frame validator: checks a 16-byte big-endian header
// (magic, version, type, flags, payload length, checksum) and the payload's
// shift-XOR checksum, giving one verdict per message on its last byte.
// Takes one byte per cycle with back-to-back transactions; a verdict passes
// from the input register to the result register and then to the master side.
// The input register and the result register bound the path, so only a verdict
// stalled at the output holds off the input. Error codes: 0 ok, 1 short,
// 2 magic, 3 version, 4 length, 5 checksum, first failing check wins.
// Depends on mfv_pkg, mfv_cfg and mfv_core.
`default_nettype none
module message_frame_validator_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [mfv_pkg::CFG_ADDR_W-1:0]    paddr,
	input  wire logic [mfv_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic      [mfv_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                   pready,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// [7:0] data_byte
	input  wire logic [7:0]                        s_tdata,
	input  wire logic                              s_tlast,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// [0] message_ok, [3:1] err_code, [11:4] msg_kind,
	// [27:12] header_flags, [59:28] payload_length,
	// [91:60] computed_checksum, [95:92] zero
	output logic      [mfv_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import mfv_pkg::*;

	cfg_t    cfg;
	result_t res;

	mfv_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mfv_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {4'd0, res};

endmodule
`default_nettype wire

/* verif/tb_message_frame_validator_top.sv */
// Testbench for message_frame_validator_top: streams framed messages byte by byte, predicts
// each verdict in-line and checks it field by field against the master-side stream.
// Depends on mfv_pkg and the validator RTL only.
module tb_message_frame_validator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mfv_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	beat_t byte_q[$];
	result_t verdict_q[$];
	logic [7:0] payload_buf[$];
	int unsigned queued_bytes = 0;
	int unsigned queued_frames = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned cycles = 0;
	bit fail_seen = 1'b0;

	logic [31:0] cfg_magic = MAGIC_RESET;
	logic [7:0] cfg_version = VERSION_RESET;

	logic [CNT_W-1:0] byte_cnt = '0;
	logic [31:0] magic_acc = '0;
	logic [7:0] version_acc = '0;
	logic [7:0] type_acc = '0;
	logic [15:0] flags_acc = '0;
	logic [31:0] length_acc = '0;
	logic [31:0] rx_checksum = '0;
	logic [31:0] run_checksum = '0;

	message_frame_validator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	task automatic track_frame_byte(input logic [7:0] b, input logic last);
		result_t r;
		err_t code;
		logic is_short;
		if (byte_cnt < HEADER_BYTES) begin
			case (byte_cnt[3:0])
				4'd0, 4'd1, 4'd2, 4'd3: magic_acc = {magic_acc[23:0], b};
				4'd4: version_acc = b;
				4'd5: type_acc = b;
				4'd6, 4'd7: flags_acc = {flags_acc[7:0], b};
				4'd8, 4'd9, 4'd10, 4'd11: length_acc = {length_acc[23:0], b};
				default: rx_checksum = {rx_checksum[23:0], b};
			endcase
		end else begin
			run_checksum = {run_checksum[30:0], 1'b0} ^ {24'd0, b};
		end
		if (byte_cnt != {CNT_W{1'b1}})
			byte_cnt = byte_cnt + 1'b1;
		if (last) begin
			is_short = byte_cnt < HEADER_BYTES;
			if (is_short)
				code = ERR_SHORT;
			else if (magic_acc != cfg_magic)
				code = ERR_MAGIC;
			else if (version_acc != cfg_version)
				code = ERR_VERSION;
			else if (byte_cnt != {1'b0, length_acc} + CNT_W'(HEADER_BYTES))
				code = ERR_LENGTH;
			else if (run_checksum != rx_checksum)
				code = ERR_CHECKSUM;
			else
				code = ERR_NONE;
			r.message_ok = (code == ERR_NONE);
			r.err_code = code;
			r.msg_kind = is_short ? 8'd0 : type_acc;
			r.header_flags = is_short ? 16'd0 : flags_acc;
			r.payload_length = is_short ? 32'd0 : length_acc;
			r.computed_checksum = run_checksum;
			verdict_q.insert(verdict_q.size(), r);
			byte_cnt = '0;
			magic_acc = '0;
			version_acc = '0;
			type_acc = '0;
			flags_acc = '0;
			length_acc = '0;
			rx_checksum = '0;
			run_checksum = '0;
		end
	endtask

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t mismatch %s: expected %h, actual %h", $time, what, want, got);
			fail_seen = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_bytes
		beat_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				track_frame_byte(s_tdata, s_tlast);
			if (!(s_tvalid && !s_tready)) begin
				if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = byte_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= nxt.data;
					s_tlast <= nxt.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch_verdicts
		result_t want;
		result_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[$bits(result_t)-1:0]);
				if (verdict_q.size() == 0) begin
					$display("%0t unexpected verdict: expected none, actual %h", $time, m_tdata);
					fail_seen = 1'b1;
				end else begin
					want = verdict_q.pop_front();
					check_field("message_ok", 32'(want.message_ok), 32'(got.message_ok));
					check_field("err_code", 32'(want.err_code), 32'(got.err_code));
					check_field("msg_kind", 32'(want.msg_kind), 32'(got.msg_kind));
					check_field("header_flags", 32'(want.header_flags), 32'(got.header_flags));
					check_field("payload_length", want.payload_length, got.payload_length);
					check_field("computed_checksum", want.computed_checksum,
						got.computed_checksum);
					check_field("tdata padding", 32'd0,
						32'(m_tdata[OUT_TDATA_W-1:$bits(result_t)]));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_MAGIC)
			cfg_magic = value;
		else
			cfg_version = value[7:0];
	endtask

	task automatic random_payload(input int n);
		payload_buf.delete();
		repeat (n) payload_buf.insert(payload_buf.size(), 8'($urandom));
	endtask

	task automatic push_beats(input int n);
		for (int i = 0; i < n; i++)
			byte_q.insert(byte_q.size(), {8'($urandom), i == n - 1});
		queued_bytes += n;
		queued_frames++;
	endtask

	task automatic push_frame(input logic [31:0] magic, input logic [7:0] version,
			input logic [31:0] len, input logic [31:0] csum_xor, input logic [7:0] payload[$]);
		logic [31:0] sum;
		logic [127:0] hdr;
		sum = '0;
		foreach (payload[i])
			sum = {sum[30:0], 1'b0} ^ {24'd0, payload[i]};
		hdr = {magic, version, 8'($urandom), 16'($urandom), len, sum ^ csum_xor};
		for (int i = 0; i < HEADER_BYTES; i++)
			byte_q.insert(byte_q.size(),
				{hdr[127-8*i -: 8], i == HEADER_BYTES - 1 && payload.size() == 0});
		foreach (payload[i])
			byte_q.insert(byte_q.size(), {payload[i], i == payload.size() - 1});
		queued_bytes += HEADER_BYTES + payload.size();
		queued_frames++;
	endtask

	task automatic queue_random_message();
		int kind;
		int n;
		logic [31:0] magic;
		logic [7:0] version;
		logic [31:0] len;
		logic [31:0] cx;
		kind = $urandom_range(99);
		n = ($urandom_range(19) == 0) ? $urandom_range(64, 200) : $urandom_range(0, 16);
		if (kind < 8) begin
			push_beats($urandom_range(1, HEADER_BYTES - 1));
			return;
		end
		if (kind < 14) begin
			push_beats($urandom_range(1, 60));
			return;
		end
		random_payload(n);
		magic = cfg_magic;
		version = cfg_version;
		len = n;
		cx = '0;
		if (kind < 20) begin
			magic = ($urandom_range(1) == 0) ? cfg_magic ^ (32'd1 << $urandom_range(31)) :
				$urandom();
			if (magic == cfg_magic)
				magic = ~cfg_magic;
		end else if (kind < 26) begin
			version = cfg_version ^ (8'd1 << $urandom_range(7));
		end else if (kind < 34) begin
			case ($urandom_range(2))
				0: len = n + $urandom_range(1, 3);
				1: len = n - 1;
				default: len = $urandom();
			endcase
			if (len == n)
				len = n + 1;
		end else if (kind < 40) begin
			cx = $urandom();
			if (cx == 0)
				cx = 32'd1;
		end
		push_frame(magic, version, len, cx, payload_buf);
	endtask

	task automatic drain();
		while (byte_q.size() != 0 || s_tvalid || verdict_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_phase();
		int unsigned b0;
		int unsigned f0;
		b0 = queued_bytes;
		f0 = queued_frames;
		while (queued_bytes - b0 < 220 || queued_frames - f0 < 8)
			queue_random_message();
		drain();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		random_payload(0);
		push_frame(cfg_magic, cfg_version, 32'd0, 32'd0, payload_buf);
		payload_buf = '{8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h80};
		push_frame(cfg_magic, cfg_version, 32'd5, 32'd0, payload_buf);
		push_beats(1);
		push_beats(HEADER_BYTES - 1);
		random_payload(3);
		push_frame(cfg_magic ^ 32'h8000_0000, cfg_version, 32'd3, 32'd0, payload_buf);
		random_payload(2);
		push_frame(cfg_magic, cfg_version ^ 8'h80, 32'd2, 32'd0, payload_buf);
		random_payload(4);
		push_frame(cfg_magic, cfg_version, 32'hFFFF_FFFF, 32'd0, payload_buf);
		random_payload(4);
		push_frame(cfg_magic, cfg_version, 32'd5, 32'd0, payload_buf);
		random_payload(6);
		push_frame(cfg_magic, cfg_version, 32'd6, 32'd1, payload_buf);
		random_payload(2);
		push_frame(~cfg_magic, ~cfg_version, 32'd7, 32'd1, payload_buf);
		random_payload(2);
		push_frame(cfg_magic, ~cfg_version, 32'd9, 32'd1, payload_buf);
		random_payload(3);
		push_frame(cfg_magic, cfg_version, 32'd1, 32'd1, payload_buf);
		random_payload(40);
		push_frame(cfg_magic, cfg_version, 32'd40, 32'd0, payload_buf);
		random_phase();

		write_reg(REG_MAGIC, 32'h0000_0000);
		write_reg(REG_VERSION, 32'h0000_0000);
		send_idle_pct = 71;
		recv_stall_pct = 0;
		random_phase();

		write_reg(REG_MAGIC, 32'hFFFF_FFFF);
		write_reg(REG_VERSION, 32'h0000_00FF);
		send_idle_pct = 0;
		recv_stall_pct = 71;
		random_phase();

		write_reg(REG_MAGIC, $urandom());
		write_reg(REG_VERSION, $urandom_range(255));
		send_idle_pct = 9;
		recv_stall_pct = 9;
		random_phase();

		if (fail_seen)
			$display("tb: failure");
		else
			$display("tb: success");
		$finish;
	end

endmodule

/* message_frame_validator_top.f */
sv/mfv_pkg.sv
sv/mfv_cfg.sv
sv/mfv_core.sv
sv/message_frame_validator_top.sv
verif/tb_message_frame_validator_top.sv
